[rtl/ofv_pkg.sv]
// ofv_pkg: shared constants for the orthonormal frame core
// no dependencies
`timescale 1ns / 1ps

package ofv_pkg;
   localparam int IN_WIDTH_DEF = 16;
   localparam int OUT_FRAC_DEF = 14;
   localparam int OUT_W        = 16;
   // three rows of three cosines
   localparam int NUM_LANES    = 9;
endpackage

[rtl/ofv_if.sv]
// ofv_req_if and ofv_rsp_if: valid/ready channels of the frame core
// depends on ofv_pkg
`timescale 1ns / 1ps

interface ofv_req_if import ofv_pkg::*; #(parameter int W = IN_WIDTH_DEF) ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] axis_x;
   logic signed [W-1:0] axis_y;
   logic signed [W-1:0] axis_z;
   logic signed [W-1:0] plane_x;
   logic signed [W-1:0] plane_y;
   logic signed [W-1:0] plane_z;
   modport source (output valid, axis_x, axis_y, axis_z, plane_x, plane_y, plane_z,
                   input ready);
   modport sink (input valid, axis_x, axis_y, axis_z, plane_x, plane_y, plane_z,
                 output ready);
endinterface

interface ofv_rsp_if import ofv_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] row0_c0;
   logic signed [OUT_W-1:0] row0_c1;
   logic signed [OUT_W-1:0] row0_c2;
   logic signed [OUT_W-1:0] row1_c0;
   logic signed [OUT_W-1:0] row1_c1;
   logic signed [OUT_W-1:0] row1_c2;
   logic signed [OUT_W-1:0] row2_c0;
   logic signed [OUT_W-1:0] row2_c1;
   logic signed [OUT_W-1:0] row2_c2;
   logic                    invalid;
   modport source (output valid, row0_c0, row0_c1, row0_c2, row1_c0, row1_c1, row1_c2,
                   row2_c0, row2_c1, row2_c2, invalid, input ready);
   modport sink (input valid, row0_c0, row0_c1, row0_c2, row1_c0, row1_c1, row1_c2,
                 row2_c0, row2_c1, row2_c2, invalid, output ready);
endinterface

[rtl/ofv_front.sv]
// ofv_front: cross products, magnitudes and squared norms, seven stages
// depends on ofv_pkg
`timescale 1ns / 1ps

module ofv_front import ofv_pkg::*; #(
   parameter int W = IN_WIDTH_DEF,
   parameter int F = OUT_FRAC_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [W-1:0] ax [3],
   input  logic signed [W-1:0] pl [3],
   output logic                out_valid,
   input  logic                out_ready,
   output logic [2*(3*W+2)+2*F+3:0] out_d [NUM_LANES],
   output logic [2*(3*W+2)+1:0]     out_s [NUM_LANES],
   output logic                out_neg [NUM_LANES],
   output logic                out_bad
);
   localparam int ZW = 2*W + 1;
   localparam int PW = ZW + W;
   localparam int MW = 3*W + 2;
   localparam int HB = (MW + 1) / 2;
   localparam int HW = MW - HB;
   localparam int SW = 2*MW + 2;
   localparam int RW = SW + 2*F + 2;
   localparam int NS = 7;

   logic [NS-1:0] v_ff;
   logic [NS:0]   en;

   logic signed [2*W-1:0] pr0_ff [6];
   logic signed [W-1:0]   x0_ff [3];
   logic signed [ZW-1:0]  z1_ff [3];
   logic signed [W-1:0]   x1_ff [3];
   logic signed [PW-1:0]  yp2_ff [6];
   logic signed [ZW-1:0]  z2_ff [3];
   logic signed [W-1:0]   x2_ff [3];
   logic signed [MW-1:0]  c3_ff [NUM_LANES];
   logic [2*HW-1:0]       hh4_ff [NUM_LANES];
   logic [HW+HB-1:0]      hl4_ff [NUM_LANES];
   logic [2*HB-1:0]       ll4_ff [NUM_LANES];
   logic                  n4_ff [NUM_LANES];
   logic [2*MW-1:0]       sq5_ff [NUM_LANES];
   logic                  n5_ff [NUM_LANES];
   logic [SW-1:0]         rs5 [3];
   logic [RW-1:0]         d6_ff [NUM_LANES];
   logic [SW-1:0]         s6_ff [NUM_LANES];
   logic                  n6_ff [NUM_LANES];
   logic                  bad6_ff;

   // stage advance chain, a stage moves when empty or its successor moves
   always_comb begin
      en[NS] = out_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end
   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            if (en[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // cross products z = x cross p, then y = z cross x
   for (genvar i = 0; i < 3; i++) begin : g_cross
      localparam int A = (i + 1) % 3;
      localparam int B = (i + 2) % 3;
      always_ff @(posedge clock) begin
         if (en[0]) begin
            pr0_ff[2*i]   <= ax[A] * pl[B];
            pr0_ff[2*i+1] <= ax[B] * pl[A];
            x0_ff[i]      <= ax[i];
         end
         if (en[1]) begin
            z1_ff[i] <= ZW'(pr0_ff[2*i]) - ZW'(pr0_ff[2*i+1]);
            x1_ff[i] <= x0_ff[i];
         end
         if (en[2]) begin
            yp2_ff[2*i]   <= z1_ff[A] * x1_ff[B];
            yp2_ff[2*i+1] <= z1_ff[B] * x1_ff[A];
            z2_ff[i]      <= z1_ff[i];
            x2_ff[i]      <= x1_ff[i];
         end
         if (en[3]) begin
            c3_ff[i]   <= MW'(x2_ff[i]);
            c3_ff[3+i] <= MW'(yp2_ff[2*i]) - MW'(yp2_ff[2*i+1]);
            c3_ff[6+i] <= MW'(z2_ff[i]);
         end
      end
   end

   // magnitude split in halves, squared by partial products
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      localparam int R = l / 3;
      logic [MW-1:0] mag;
      assign mag = c3_ff[l][MW-1] ? $unsigned(-c3_ff[l]) : $unsigned(c3_ff[l]);
      always_ff @(posedge clock) begin
         if (en[4]) begin
            hh4_ff[l] <= mag[MW-1:HB] * mag[MW-1:HB];
            hl4_ff[l] <= mag[MW-1:HB] * mag[HB-1:0];
            ll4_ff[l] <= mag[HB-1:0] * mag[HB-1:0];
            n4_ff[l]  <= c3_ff[l][MW-1];
         end
         if (en[5]) begin
            sq5_ff[l] <= ((2*MW)'(hh4_ff[l]) << (2*HB)) + ((2*MW)'(hl4_ff[l]) << (HB + 1))
                         + (2*MW)'(ll4_ff[l]);
            n5_ff[l]  <= n4_ff[l];
         end
         if (en[6]) begin
            d6_ff[l] <= RW'(sq5_ff[l]) << (2*F + 2);
            s6_ff[l] <= rs5[R];
            n6_ff[l] <= n5_ff[l];
         end
      end
   end

   // squared norm of each row
   for (genvar r = 0; r < 3; r++) begin : g_row
      assign rs5[r] = SW'(sq5_ff[3*r]) + SW'(sq5_ff[3*r+1]) + SW'(sq5_ff[3*r+2]);
   end

   always_ff @(posedge clock) begin
      if (en[6]) bad6_ff <= (rs5[0] == '0) || (rs5[1] == '0) || (rs5[2] == '0);
   end

   assign out_d   = d6_ff;
   assign out_s   = s6_ff;
   assign out_neg = n6_ff;
   assign out_bad = bad6_ff;
endmodule

[rtl/ofv_cell.sv]
// ofv_cell: one quotient bit of the scaled square root of d / s, all lanes
// depends on ofv_pkg
`timescale 1ns / 1ps

module ofv_cell import ofv_pkg::*; #(
   parameter int SW = 102,
   parameter int F  = OUT_FRAC_DEF,
   parameter int K  = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SW+2*F+1:0]   in_d [NUM_LANES],
   input  logic [SW+F+1:0]     in_a [NUM_LANES],
   input  logic [F+1:0]        in_u [NUM_LANES],
   input  logic [SW-1:0]       in_s [NUM_LANES],
   input  logic                in_neg [NUM_LANES],
   input  logic                in_bad,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [SW+2*F+1:0]   out_d [NUM_LANES],
   output logic [SW+F+1:0]     out_a [NUM_LANES],
   output logic [F+1:0]        out_u [NUM_LANES],
   output logic [SW-1:0]       out_s [NUM_LANES],
   output logic                out_neg [NUM_LANES],
   output logic                out_bad
);
   localparam int RW = SW + 2*F + 2;
   localparam int AW = SW + F + 2;
   localparam int UW = F + 2;
   localparam int TW = RW + 3;

   logic                v_ff;
   logic [RW-1:0]       d_ff [NUM_LANES];
   logic [AW-1:0]       a_ff [NUM_LANES];
   logic [UW-1:0]       u_ff [NUM_LANES];
   logic [SW-1:0]       s_ff [NUM_LANES];
   logic                n_ff [NUM_LANES];
   logic                bad_ff;
   logic                en;

   assign in_ready = !v_ff || out_ready;
   assign en       = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   // trial bit: (u + 2^k)^2 s = u^2 s + 2^(k+1) u s + 4^k s
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [TW-1:0] term;
      logic          take;
      assign term = (TW'(in_a[l]) << (K + 1)) + (TW'(in_s[l]) << (2*K));
      assign take = term <= TW'(in_d[l]);
      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[l] <= take ? in_d[l] - RW'(term) : in_d[l];
            a_ff[l] <= take ? in_a[l] + (AW'(in_s[l]) << K) : in_a[l];
            u_ff[l] <= take ? in_u[l] | (UW'(1) << K) : in_u[l];
            s_ff[l] <= in_s[l];
            n_ff[l] <= in_neg[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) bad_ff <= in_bad;
   end

   assign out_valid = v_ff;
   assign out_d     = d_ff;
   assign out_a     = a_ff;
   assign out_u     = u_ff;
   assign out_s     = s_ff;
   assign out_neg   = n_ff;
   assign out_bad   = bad_ff;
endmodule

[rtl/orthonormal_frame_from_two_vectors_core.sv]
// orthonormal_frame_from_two_vectors_core: direction cosine matrix from two vectors
// depends on ofv_pkg, ofv_if, ofv_front, ofv_cell
//
//   channel  dir  beat contents
//   req      in   axis_x/y/z, plane_x/y/z (signed IN_WIDTH)
//   rsp      out  row0..row2 cosines c0..c2 (signed Q1.OUT_FRAC, 16 bits), invalid
//
// one beat in and one beat out per cycle while rsp.ready does not stall the pipe, which holds:
// seven front stages, a row of OUT_FRAC + 2 cells (one quotient bit each), one output register
// synchronous reset clears only the valid flags
// each stage holds its beat while the next one is full and stalled
`timescale 1ns / 1ps

module orthonormal_frame_from_two_vectors_core import ofv_pkg::*; #(
   parameter int IN_WIDTH = IN_WIDTH_DEF,
   parameter int OUT_FRAC = OUT_FRAC_DEF
) (
   input logic        clock,
   input logic        reset,
   ofv_req_if.sink    req,
   ofv_rsp_if.source  rsp
);
   localparam int MW = 3*IN_WIDTH + 2;
   localparam int SW = 2*MW + 2;
   localparam int RW = SW + 2*OUT_FRAC + 2;
   localparam int AW = SW + OUT_FRAC + 2;
   localparam int UW = OUT_FRAC + 2;
   localparam int NC = OUT_FRAC + 2;
   localparam int QX = (OUT_FRAC + 3 > OUT_W) ? OUT_FRAC + 3 : OUT_W;

   logic signed [IN_WIDTH-1:0] ax [3];
   logic signed [IN_WIDTH-1:0] pl [3];

   logic          c_valid [NC+1];
   logic          c_ready [NC+1];
   logic [RW-1:0] c_d   [NC+1][NUM_LANES];
   logic [AW-1:0] c_a   [NC+1][NUM_LANES];
   logic [UW-1:0] c_u   [NC+1][NUM_LANES];
   logic [SW-1:0] c_s   [NC+1][NUM_LANES];
   logic          c_neg [NC+1][NUM_LANES];
   logic          c_bad [NC+1];

   logic                    o_valid_ff;
   logic signed [OUT_W-1:0] o_cos_ff [NUM_LANES];
   logic                    o_bad_ff;
   logic signed [OUT_W-1:0] cos_in [NUM_LANES];

   assign ax[0] = req.axis_x;
   assign ax[1] = req.axis_y;
   assign ax[2] = req.axis_z;
   assign pl[0] = req.plane_x;
   assign pl[1] = req.plane_y;
   assign pl[2] = req.plane_z;

   // cross products and squared norms
   ofv_front #(.W(IN_WIDTH), .F(OUT_FRAC)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .ax        (ax),
      .pl        (pl),
      .out_valid (c_valid[0]),
      .out_ready (c_ready[0]),
      .out_d     (c_d[0]),
      .out_s     (c_s[0]),
      .out_neg   (c_neg[0]),
      .out_bad   (c_bad[0])
   );

   // quotient starts at zero
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_init
      assign c_a[0][l] = '0;
      assign c_u[0][l] = '0;
   end

   // row of cells, most significant quotient bit first
   for (genvar g = 0; g < NC; g++) begin : g_cell
      ofv_cell #(.SW(SW), .F(OUT_FRAC), .K(OUT_FRAC + 1 - g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[g]),
         .in_ready  (c_ready[g]),
         .in_d      (c_d[g]),
         .in_a      (c_a[g]),
         .in_u      (c_u[g]),
         .in_s      (c_s[g]),
         .in_neg    (c_neg[g]),
         .in_bad    (c_bad[g]),
         .out_valid (c_valid[g+1]),
         .out_ready (c_ready[g+1]),
         .out_d     (c_d[g+1]),
         .out_a     (c_a[g+1]),
         .out_u     (c_u[g+1]),
         .out_s     (c_s[g+1]),
         .out_neg   (c_neg[g+1]),
         .out_bad   (c_bad[g+1])
      );
   end

   // round half up on the doubled quotient, apply sign, zero when invalid
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_round
      logic [UW:0]          q;
      logic signed [QX-1:0] sv;
      assign q  = ((UW + 1)'(c_u[NC][l]) + (UW + 1)'(1)) >> 1;
      assign sv = c_neg[NC][l] ? -$signed(QX'(q)) : $signed(QX'(q));
      assign cos_in[l] = c_bad[NC] ? '0 : sv[OUT_W-1:0];
   end

   // output register
   assign c_ready[NC] = !o_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (c_ready[NC]) begin
         o_valid_ff <= c_valid[NC];
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready[NC] && c_valid[NC]) begin
         o_cos_ff <= cos_in;
         o_bad_ff <= c_bad[NC];
      end
   end

   assign rsp.valid   = o_valid_ff;
   assign rsp.row0_c0 = o_cos_ff[0];
   assign rsp.row0_c1 = o_cos_ff[1];
   assign rsp.row0_c2 = o_cos_ff[2];
   assign rsp.row1_c0 = o_cos_ff[3];
   assign rsp.row1_c1 = o_cos_ff[4];
   assign rsp.row1_c2 = o_cos_ff[5];
   assign rsp.row2_c0 = o_cos_ff[6];
   assign rsp.row2_c1 = o_cos_ff[7];
   assign rsp.row2_c2 = o_cos_ff[8];
   assign rsp.invalid = o_bad_ff;
endmodule
